// ----- src/scar_pkg.sv -----
// shared package for the stereo comb/allpass reverberator
// types, constants, delay length tables and saturation helpers; no dependencies
package scar_pkg;

	localparam int MAX_DELAY     = 2048;
	localparam int COMB_COUNT    = 8;
	localparam int ALLPASS_COUNT = 4;
	localparam int SAMPLE_WIDTH  = 24;
	localparam int SAMPLE_RATE   = 44100;
	localparam int RATE_BASE     = 44100;
	localparam int SPREAD        = 23;

	localparam int WORD_W    = 32;
	localparam int GAIN_W    = 17;
	localparam int COEF_W    = 18;
	localparam int CFG_W     = 18;
	localparam int CFG_IDX_W = 3;
	localparam int IDX_W     = 3;
	localparam int PROD_W    = 50;
	localparam int ACC_W     = 53;
	localparam int SUM_W     = WORD_W + IDX_W;

	localparam logic signed [COEF_W-1:0] DAMP1 = 18'sd3277;
	localparam logic signed [COEF_W-1:0] DAMP2 = 18'sd62259;
	localparam logic [GAIN_W-1:0] UNITY = 17'd65536;

	localparam logic [CFG_IDX_W-1:0] REG_ROOM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WET  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd5;

	localparam logic [GAIN_W-1:0] ROOM_RESET = 17'd52429;
	localparam logic [GAIN_W-1:0] WET_RESET  = 17'd16384;
	localparam logic [GAIN_W-1:0] DRY_RESET  = 17'd49152;

	localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

	function automatic int scale_rate(input int base);
		int n;
		n = base * SAMPLE_RATE / RATE_BASE;
		return (n == 0) ? 1 : n;
	endfunction

	// delay lengths per channel, before clamping to the buffer size
	localparam int COMB_LEN [2][8] = '{
		'{scale_rate(1116), scale_rate(1188), scale_rate(1277), scale_rate(1356),
		  scale_rate(1422), scale_rate(1491), scale_rate(1557), scale_rate(1617)},
		'{scale_rate(1116 + SPREAD), scale_rate(1188 + SPREAD), scale_rate(1277 + SPREAD),
		  scale_rate(1356 + SPREAD), scale_rate(1422 + SPREAD), scale_rate(1491 + SPREAD),
		  scale_rate(1557 + SPREAD), scale_rate(1617 + SPREAD)}
	};
	localparam int AP_LEN [2][4] = '{
		'{scale_rate(556), scale_rate(441), scale_rate(341), scale_rate(225)},
		'{scale_rate(556 + SPREAD), scale_rate(441 + SPREAD), scale_rate(341 + SPREAD),
		  scale_rate(224 + SPREAD)}
	};

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_MEM_DAMP2,
		MUL_DAMP_DAMP1,
		MUL_F_ROOM,
		MUL_MEM_ROOM,
		MUL_Y_B0,
		MUL_H1_B0,
		MUL_H2_A1,
		MUL_H3_A2,
		MUL_Y_WET,
		MUL_IN_DRY
	} mul_op_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB,
		ACC_LOAD19,
		ACC_ADD16
	} acc_op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_C_RD, ST_C_CAP, ST_C_M2, ST_C_M3, ST_C_M4, ST_C_F, ST_C_M5, ST_C_WR,
		ST_A_RD, ST_A_CAP, ST_A_MUL, ST_A_WR,
		ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5,
		ST_M0, ST_M1, ST_M2, ST_M3
	} state_t;

	typedef struct packed {
		logic             clear;
		logic             load_in;
		logic             sum_clr;
		logic             comb_rd;
		logic             comb_cap;
		logic             damp_wr;
		logic             comb_wr;
		logic             ap_rd;
		logic             ap_cap;
		logic             ld_y_sum;
		logic             ap_wr;
		logic             bq_upd;
		logic             mix_l;
		logic             out_load;
		mul_op_t          mul_op;
		acc_op_t          acc_op;
		logic             ch;
		logic [IDX_W-1:0] k;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic out_free;
	} dp_stat_t;

	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			return 32'sh8000_0000;
		else
			return v[WORD_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(input logic signed [63:0] v);
		if (v > OUT_MAX)
			return OUT_MAX[SAMPLE_WIDTH-1:0];
		else if (v < OUT_MIN)
			return OUT_MIN[SAMPLE_WIDTH-1:0];
		else
			return v[SAMPLE_WIDTH-1:0];
	endfunction

	function automatic logic [GAIN_W-1:0] gain_clamp(input logic [GAIN_W-1:0] v);
		return (v > UNITY) ? UNITY : v;
	endfunction

endpackage

// ----- src/scar_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module scar_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ----- src/scar_ctrl.sv -----
// sequencer for the reverberator: walks combs, allpasses, biquad and mix per channel
// depends on scar_pkg
module scar_ctrl #(
	parameter int COMB_COUNT    = scar_pkg::COMB_COUNT,
	parameter int ALLPASS_COUNT = scar_pkg::ALLPASS_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  scar_pkg::dp_stat_t stat,
	output scar_pkg::ctl_cmd_t cmd
);
	import scar_pkg::*;

	state_t           state_q, state_d;
	logic             ch_q, ch_d;
	logic [IDX_W-1:0] k_q, k_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ch_q    <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ch_d     = ch_q;
		k_d      = k_q;
		cmd      = '0;
		cmd.ch   = ch_q;
		cmd.k    = k_q;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.sum_clr = 1'b1;
					ch_d        = 1'b0;
					k_d         = '0;
					state_d     = ST_C_RD;
				end
			end
			ST_C_RD: begin
				cmd.comb_rd = 1'b1;
				state_d     = ST_C_CAP;
			end
			ST_C_CAP: begin
				cmd.comb_cap = 1'b1;
				state_d      = ST_C_M2;
			end
			ST_C_M2: begin
				cmd.mul_op = MUL_MEM_DAMP2;
				state_d    = ST_C_M3;
			end
			ST_C_M3: begin
				cmd.mul_op = MUL_DAMP_DAMP1;
				cmd.acc_op = ACC_LOAD;
				state_d    = ST_C_M4;
			end
			ST_C_M4: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_C_F;
			end
			ST_C_F: begin
				cmd.damp_wr = 1'b1;
				state_d     = ST_C_M5;
			end
			ST_C_M5: begin
				cmd.mul_op = MUL_F_ROOM;
				state_d    = ST_C_WR;
			end
			ST_C_WR: begin
				cmd.comb_wr = 1'b1;
				if (k_q == IDX_W'(COMB_COUNT - 1)) begin
					k_d     = '0;
					state_d = ST_A_RD;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_C_RD;
				end
			end
			ST_A_RD: begin
				cmd.ap_rd    = 1'b1;
				cmd.ld_y_sum = (k_q == '0);
				state_d      = ST_A_CAP;
			end
			ST_A_CAP: begin
				cmd.ap_cap = 1'b1;
				state_d    = ST_A_MUL;
			end
			ST_A_MUL: begin
				cmd.mul_op = MUL_MEM_ROOM;
				state_d    = ST_A_WR;
			end
			ST_A_WR: begin
				cmd.ap_wr = 1'b1;
				if (k_q == IDX_W'(ALLPASS_COUNT - 1)) begin
					k_d     = '0;
					state_d = ST_B0;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_A_RD;
				end
			end
			ST_B0: begin
				cmd.mul_op = MUL_Y_B0;
				state_d    = ST_B1;
			end
			ST_B1: begin
				cmd.mul_op = MUL_H1_B0;
				cmd.acc_op = ACC_LOAD;
				state_d    = ST_B2;
			end
			ST_B2: begin
				cmd.mul_op = MUL_H2_A1;
				cmd.acc_op = ACC_SUB;
				state_d    = ST_B3;
			end
			ST_B3: begin
				cmd.mul_op = MUL_H3_A2;
				cmd.acc_op = ACC_SUB;
				state_d    = ST_B4;
			end
			ST_B4: begin
				cmd.acc_op = ACC_SUB;
				state_d    = ST_B5;
			end
			ST_B5: begin
				cmd.bq_upd = 1'b1;
				state_d    = ST_M0;
			end
			ST_M0: begin
				cmd.mul_op = MUL_Y_WET;
				state_d    = ST_M1;
			end
			ST_M1: begin
				cmd.mul_op = MUL_IN_DRY;
				cmd.acc_op = ACC_LOAD19;
				state_d    = ST_M2;
			end
			ST_M2: begin
				cmd.acc_op = ACC_ADD16;
				state_d    = ST_M3;
			end
			ST_M3: begin
				if (!ch_q) begin
					cmd.mix_l   = 1'b1;
					cmd.sum_clr = 1'b1;
					ch_d        = 1'b1;
					k_d         = '0;
					state_d     = ST_C_RD;
				end else if (stat.out_free) begin
					// hold here until the output register can take the pair
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// ----- src/scar_dp.sv -----
// datapath: delay memories, filter state, shared multiplier and accumulator, output register
// depends on scar_pkg and scar_ram
module scar_dp #(
	parameter int MAX_DELAY     = scar_pkg::MAX_DELAY,
	parameter int COMB_COUNT    = scar_pkg::COMB_COUNT,
	parameter int ALLPASS_COUNT = scar_pkg::ALLPASS_COUNT
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  scar_pkg::ctl_cmd_t                         cmd,
	output scar_pkg::dp_stat_t                         stat,
	input  logic                                       cfg_write,
	input  logic [scar_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [scar_pkg::CFG_W-1:0]                 cfg_data,
	input  logic signed [scar_pkg::SAMPLE_WIDTH-1:0]   left_in,
	input  logic signed [scar_pkg::SAMPLE_WIDTH-1:0]   right_in,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic signed [scar_pkg::SAMPLE_WIDTH-1:0]   left_out,
	output logic signed [scar_pkg::SAMPLE_WIDTH-1:0]   right_out
);
	import scar_pkg::*;

	localparam int PW         = $clog2(MAX_DELAY);
	localparam int CSW        = $clog2(2 * COMB_COUNT);
	localparam int ASW        = $clog2(2 * ALLPASS_COUNT);
	localparam int COMB_DEPTH = (2 * COMB_COUNT) << PW;
	localparam int AP_DEPTH   = (2 * ALLPASS_COUNT) << PW;
	localparam int CAW        = CSW + PW;
	localparam int AAW        = ASW + PW;
	localparam int CLR_DEPTH  = (COMB_DEPTH > AP_DEPTH) ? COMB_DEPTH : AP_DEPTH;
	localparam int CLW        = $clog2(CLR_DEPTH);

	logic [GAIN_W-1:0]        room_q, wet_q, dry_q;
	logic signed [COEF_W-1:0] b0_q, a1_q, a2_q;

	logic signed [SAMPLE_WIDTH-1:0] in_l_q, in_r_q, mix_l_q;
	logic signed [SAMPLE_WIDTH-1:0] left_out_q, right_out_q;
	logic                           out_valid_q;

	logic [PW-1:0]            comb_ptr_q [2*COMB_COUNT];
	logic signed [WORD_W-1:0] damp_q     [2*COMB_COUNT];
	logic [PW-1:0]            ap_ptr_q   [2*ALLPASS_COUNT];
	logic signed [WORD_W-1:0] h0_q [2];
	logic signed [WORD_W-1:0] h1_q [2];
	logic signed [WORD_W-1:0] h2_q [2];
	logic signed [WORD_W-1:0] h3_q [2];

	logic signed [WORD_W-1:0] mem_q, y_q, f_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [CLW-1:0]           clr_q;

	logic signed [WORD_W-1:0] x, acc_sat, comb_wd, ap_wd, ap_out;
	logic signed [WORD_W-1:0] comb_rdata, ap_rdata;
	logic signed [WORD_W-1:0] mul_a;
	logic signed [COEF_W-1:0] mul_b;
	logic signed [SAMPLE_WIDTH-1:0] mix;
	logic [CSW-1:0]           slot_c;
	logic [ASW-1:0]           slot_a;
	logic [PW-1:0]            cptr, aptr, cptr_nx, aptr_nx;
	logic [PW:0]              clen, alen;
	int                       clen_raw, alen_raw;
	logic                     comb_we, ap_we, clr_comb, clr_ap;
	logic [CAW-1:0]           comb_waddr, comb_raddr;
	logic [AAW-1:0]           ap_waddr, ap_raddr;

	assign x       = WORD_W'(cmd.ch ? in_r_q : in_l_q);
	assign slot_c  = CSW'(int'(cmd.ch) * COMB_COUNT + int'(cmd.k));
	assign slot_a  = ASW'(int'(cmd.ch) * ALLPASS_COUNT + int'(cmd.k));
	assign cptr    = comb_ptr_q[slot_c];
	assign aptr    = ap_ptr_q[slot_a];

	always_comb begin
		clen_raw = COMB_LEN[cmd.ch][cmd.k];
		alen_raw = AP_LEN[cmd.ch][cmd.k[1:0]];
		clen     = (PW+1)'((clen_raw > MAX_DELAY) ? MAX_DELAY : clen_raw);
		alen     = (PW+1)'((alen_raw > MAX_DELAY) ? MAX_DELAY : alen_raw);
	end

	// wrap the pointer at the channel's delay length
	assign cptr_nx = (({1'b0, cptr} + 1'b1) >= clen) ? '0 : cptr + 1'b1;
	assign aptr_nx = (({1'b0, aptr} + 1'b1) >= alen) ? '0 : aptr + 1'b1;

	assign acc_sat = sat32(64'(acc_q >>> 16));
	assign comb_wd = sat32(64'(x) + 64'(prod_q >>> 16));
	assign ap_wd   = sat32(64'(y_q) + 64'(prod_q >>> 16));
	assign ap_out  = sat32(64'(mem_q) - 64'(y_q));
	assign mix     = sat_out(64'(acc_q >>> 1));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			MUL_MEM_DAMP2:  begin mul_a = mem_q;          mul_b = DAMP2; end
			MUL_DAMP_DAMP1: begin mul_a = damp_q[slot_c]; mul_b = DAMP1; end
			MUL_F_ROOM:     begin mul_a = f_q;   mul_b = signed'({1'b0, room_q}); end
			MUL_MEM_ROOM:   begin mul_a = mem_q; mul_b = signed'({1'b0, room_q}); end
			MUL_Y_B0:       begin mul_a = y_q;              mul_b = b0_q; end
			MUL_H1_B0:      begin mul_a = h1_q[cmd.ch];     mul_b = b0_q; end
			MUL_H2_A1:      begin mul_a = h2_q[cmd.ch];     mul_b = a1_q; end
			MUL_H3_A2:      begin mul_a = h3_q[cmd.ch];     mul_b = a2_q; end
			MUL_Y_WET:      begin mul_a = y_q;   mul_b = signed'({1'b0, wet_q}); end
			MUL_IN_DRY:     begin mul_a = x;     mul_b = signed'({1'b0, dry_q}); end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// clearing pass shares one counter for both memories
	assign clr_comb   = cmd.clear && ({1'b0, clr_q} < (CLW+1)'(COMB_DEPTH));
	assign clr_ap     = cmd.clear && ({1'b0, clr_q} < (CLW+1)'(AP_DEPTH));
	assign comb_we    = clr_comb || cmd.comb_wr;
	assign ap_we      = clr_ap || cmd.ap_wr;
	assign comb_raddr = {slot_c, cptr};
	assign ap_raddr   = {slot_a, aptr};
	assign comb_waddr = cmd.clear ? clr_q[CAW-1:0] : comb_raddr;
	assign ap_waddr   = cmd.clear ? clr_q[AAW-1:0] : ap_raddr;

	scar_ram #(.WIDTH(WORD_W), .DEPTH(COMB_DEPTH)) u_comb_ram (
		.clk   (clk),
		.we    (comb_we),
		.waddr (comb_waddr),
		.wdata (cmd.clear ? '0 : comb_wd),
		.re    (cmd.comb_rd),
		.raddr (comb_raddr),
		.rdata (comb_rdata)
	);

	scar_ram #(.WIDTH(WORD_W), .DEPTH(AP_DEPTH)) u_ap_ram (
		.clk   (clk),
		.we    (ap_we),
		.waddr (ap_waddr),
		.wdata (cmd.clear ? '0 : ap_wd),
		.re    (cmd.ap_rd),
		.raddr (ap_raddr),
		.rdata (ap_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q      <= ROOM_RESET;
			wet_q       <= WET_RESET;
			dry_q       <= DRY_RESET;
			b0_q        <= '0;
			a1_q        <= '0;
			a2_q        <= '0;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
			for (int i = 0; i < 2*COMB_COUNT; i++) begin
				comb_ptr_q[i] <= '0;
				damp_q[i]     <= '0;
			end
			for (int i = 0; i < 2*ALLPASS_COUNT; i++)
				ap_ptr_q[i] <= '0;
			for (int i = 0; i < 2; i++) begin
				h0_q[i] <= '0;
				h1_q[i] <= '0;
				h2_q[i] <= '0;
				h3_q[i] <= '0;
			end
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ROOM: room_q <= gain_clamp(cfg_data[GAIN_W-1:0]);
					REG_WET:  wet_q  <= gain_clamp(cfg_data[GAIN_W-1:0]);
					REG_DRY:  dry_q  <= gain_clamp(cfg_data[GAIN_W-1:0]);
					REG_B0:   b0_q   <= signed'(cfg_data[COEF_W-1:0]);
					REG_A1:   a1_q   <= signed'(cfg_data[COEF_W-1:0]);
					REG_A2:   a2_q   <= signed'(cfg_data[COEF_W-1:0]);
					default: begin
					end
				endcase
			end
			if (cmd.clear)
				clr_q <= clr_q + 1'b1;
			if (cmd.damp_wr)
				damp_q[slot_c] <= acc_sat;
			if (cmd.comb_wr)
				comb_ptr_q[slot_c] <= cptr_nx;
			if (cmd.ap_wr)
				ap_ptr_q[slot_a] <= aptr_nx;
			if (cmd.bq_upd) begin
				h1_q[cmd.ch] <= h0_q[cmd.ch];
				h0_q[cmd.ch] <= y_q;
				h3_q[cmd.ch] <= h2_q[cmd.ch];
				h2_q[cmd.ch] <= acc_sat;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_l_q <= left_in;
			in_r_q <= right_in;
		end
		if (cmd.sum_clr)
			sum_q <= '0;
		else if (cmd.comb_cap)
			sum_q <= sum_q + SUM_W'(comb_rdata);
		if (cmd.comb_cap)
			mem_q <= comb_rdata;
		else if (cmd.ap_cap)
			mem_q <= ap_rdata;
		if (cmd.damp_wr)
			f_q <= acc_sat;
		if (cmd.ld_y_sum)
			y_q <= sat32(64'(sum_q));
		else if (cmd.ap_wr)
			y_q <= ap_out;
		else if (cmd.bq_upd)
			y_q <= acc_sat;
		if (cmd.mul_op != MUL_NONE)
			prod_q <= mul_a * mul_b;
		case (cmd.acc_op)
			ACC_LOAD:   acc_q <= ACC_W'(prod_q);
			ACC_ADD:    acc_q <= acc_q + ACC_W'(prod_q);
			ACC_SUB:    acc_q <= acc_q - ACC_W'(prod_q);
			ACC_LOAD19: acc_q <= ACC_W'(prod_q >>> 19);
			ACC_ADD16:  acc_q <= acc_q + ACC_W'(prod_q >>> 16);
			default: begin
			end
		endcase
		if (cmd.mix_l)
			mix_l_q <= mix;
		if (cmd.out_load) begin
			left_out_q  <= mix_l_q;
			right_out_q <= mix;
		end
	end

	assign stat.clear_done = (clr_q == CLW'(CLR_DEPTH - 1));
	assign stat.out_free   = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign left_out        = left_out_q;
	assign right_out       = right_out_q;
endmodule

// ----- src/stereo_comb_allpass_reverb_unit.sv -----
// one item at a time; the next input is taken in the cycle after the result is registered,
// and a finished pair waits in the last mix state while the output is stalled.
// the shared multiplier and the single read port of each delay memory set the step order:
// per channel, each comb in turn, then each allpass, then the biquad and the mix.
// after reset a clearing pass zeroes the delay memories; config writes are taken meanwhile
module stereo_comb_allpass_reverb_unit #(
	parameter int MAX_DELAY     = scar_pkg::MAX_DELAY,
	parameter int COMB_COUNT    = scar_pkg::COMB_COUNT,
	parameter int ALLPASS_COUNT = scar_pkg::ALLPASS_COUNT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [scar_pkg::SAMPLE_WIDTH-1:0] left_in,
	input  logic signed [scar_pkg::SAMPLE_WIDTH-1:0] right_in,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [scar_pkg::SAMPLE_WIDTH-1:0] left_out,
	output logic signed [scar_pkg::SAMPLE_WIDTH-1:0] right_out,
	input  logic                                     cfg_write,
	input  logic [scar_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [scar_pkg::CFG_W-1:0]               cfg_data
);
	import scar_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	scar_ctrl #(
		.COMB_COUNT    (COMB_COUNT),
		.ALLPASS_COUNT (ALLPASS_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	scar_dp #(
		.MAX_DELAY     (MAX_DELAY),
		.COMB_COUNT    (COMB_COUNT),
		.ALLPASS_COUNT (ALLPASS_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.left_in   (left_in),
		.right_in  (right_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.left_out  (left_out),
		.right_out (right_out)
	);
endmodule

// ----- src/scar_checker.sv -----
// port-level checks for the reverberator, bound to the top level
// depends on scar_pkg and stereo_comb_allpass_reverb_unit
module scar_checker (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     in_valid,
	input logic                                     in_ready,
	input logic                                     out_valid,
	input logic                                     out_ready,
	input logic signed [scar_pkg::SAMPLE_WIDTH-1:0] left_out,
	input logic signed [scar_pkg::SAMPLE_WIDTH-1:0] right_out
);
	// one item in flight: ready drops after an input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an input transfer");

	// a new result appears together with the block going idle
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while still busy");

	// a result only comes out of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without processing");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
		else $error("stalled result changed");
endmodule

bind stereo_comb_allpass_reverb_unit scar_checker u_scar_checker (.*);
